### rtl/i2cbs_pkg.sv
// Package with the beat types, command codes and shifter control for the I2C bit sequencer.
package i2cbs_pkg;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_NACK  = 3'd3;
    localparam logic [2:0] ACT_WAIT  = 3'd4;
    localparam logic [2:0] ACT_SEND  = 3'd5;
    localparam logic [2:0] ACT_READ  = 3'd6;
    localparam logic [2:0] ACT_NONE  = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic [7:0] sda_samples;
    } t_in_beat;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctl;

endpackage

### rtl/i2cbs_shift.sv
// Bit-serial shift registers for the transmitted byte and the sampled receive bits.
module i2cbs_shift (
    input  logic                  i_clk,
    input  i2cbs_pkg::t_shift_ctl i_ctl,
    input  logic [7:0]            i_tx_byte,
    input  logic [7:0]            i_samples,
    output logic                  o_tx_bit,
    output logic [7:0]            o_rx_next
);
    import i2cbs_pkg::*;

    logic [7:0] r_tx;
    logic [7:0] r_smp;
    logic [7:0] r_rx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tx  <= i_tx_byte;
            r_smp <= i_samples;
            r_rx  <= 8'd0;
        end else if (i_ctl.shift) begin
            r_tx  <= {r_tx[6:0], 1'b0};
            r_smp <= {r_smp[6:0], 1'b0};
            r_rx  <= {r_rx[6:0], r_smp[7]};
        end
    end

    assign o_tx_bit  = r_tx[7];
    assign o_rx_next = {r_rx[6:0], r_smp[7]};

endmodule

### rtl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: command decode, slot counters and output register.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_beat  (t_in_beat)
//   out       output     o_out_valid / i_out_stall  o_out_beat (t_out_beat)
//
// Each command produces one output beat per cycle while not stalled: 3 or 4 beats for the
// short commands, 32 for send byte and 24 for read byte; the slot counters set that figure.
// The next command is taken once the last beat of the current one is registered.
// A stalled output holds the slot counters. Reset releases SDA and empties the block.
module i2c_master_bit_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2cbs_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output i2cbs_pkg::t_out_beat o_out_beat
);
    import i2cbs_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cmd, n_cmd;
    logic [1:0] r_ph, n_ph;
    logic [2:0] r_bit, n_bit;
    logic       r_held, n_held;
    logic       r_ack, n_ack;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out_beat, n_out_beat;

    t_shift_ctl shift_ctl;
    logic       tx_bit;
    logic [7:0] rx_next;
    logic       accept;
    logic       advance;
    logic       wrap;
    t_out_beat  slot;

    i2cbs_shift u_shift (
        .i_clk     (i_clk),
        .i_ctl     (shift_ctl),
        .i_tx_byte (i_in_beat.tx_byte),
        .i_samples (i_in_beat.sda_samples),
        .o_tx_bit  (tx_bit),
        .o_rx_next (rx_next)
    );

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign advance = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        slot  = '0;
        wrap  = 1'b0;
        unique case (r_cmd) inside
            ACT_START: begin
                slot.scl_level = (r_ph != 2'd2);
                slot.sda_level = (r_ph == 2'd0);
                slot.last      = (r_ph == 2'd2);
            end
            ACT_STOP: begin
                slot.scl_level = (r_ph != 2'd0);
                slot.sda_level = (r_ph == 2'd2);
                slot.last      = (r_ph == 2'd2);
            end
            ACT_ACK: begin
                slot.scl_level = (r_ph == 2'd2);
                slot.sda_level = (r_ph == 2'd0);
                slot.last      = (r_ph == 2'd3);
            end
            ACT_NACK, ACT_WAIT: begin
                slot.scl_level = (r_ph == 2'd1);
                slot.sda_level = 1'b1;
                slot.last      = (r_ph == 2'd2);
                slot.ack_seen  = (r_cmd == ACT_WAIT) && (r_ph == 2'd2) && r_ack;
            end
            ACT_SEND: begin
                wrap           = (r_ph == 2'd3);
                slot.scl_level = (r_ph == 2'd2);
                slot.sda_level = (r_ph != 2'd0) && tx_bit;
                slot.last      = (r_bit == 3'd7) && wrap;
            end
            ACT_READ: begin
                wrap           = (r_ph == 2'd2);
                slot.scl_level = (r_ph == 2'd1);
                slot.sda_level = r_held;
                slot.last      = (r_bit == 3'd7) && wrap;
                slot.rx_byte   = slot.last ? rx_next : 8'd0;
            end
            default: begin
                slot.last = 1'b1;
            end
        endcase
    end

    assign shift_ctl.load  = accept;
    assign shift_ctl.shift = advance && wrap;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ph        = r_ph;
        n_bit       = r_bit;
        n_held      = r_held;
        n_ack       = r_ack;
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_beat.action != ACT_NONE)) begin
                    n_state = S_RUN;
                    n_cmd   = i_in_beat.action;
                    n_ph    = 2'd0;
                    n_bit   = 3'd0;
                    n_ack   = !i_in_beat.sda_samples[0];
                end
            end
            S_RUN: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_out_beat  = slot;
                    if (wrap) begin
                        n_ph  = 2'd0;
                        n_bit = r_bit + 3'd1;
                    end else begin
                        n_ph = r_ph + 2'd1;
                    end
                    if (slot.last) begin
                        n_state = S_IDLE;
                        case (r_cmd)
                            ACT_START: n_held = 1'b0;
                            ACT_SEND:  n_held = tx_bit;
                            ACT_READ:  n_held = r_held;
                            default:   n_held = 1'b1;
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_ph       <= n_ph;
        r_bit      <= n_bit;
        r_ack      <= n_ack;
        r_out_beat <= n_out_beat;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTH
    a_rx_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.rx_byte != 8'd0)) |-> o_out_beat.last)
        else $error("Received byte shown on a beat that is not the last.");

    a_ack_clock_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.ack_seen) |-> (o_out_beat.last && !o_out_beat.scl_level))
        else $error("Acknowledge flag on a wrong beat.");

    a_last_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.last && o_out_beat.scl_level) |-> o_out_beat.sda_level)
        else $error("A command ended with SCL high and SDA low.");

    a_start_holds_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && slot.last && (r_cmd == ACT_START)) |=> !r_held)
        else $error("SDA drive not held low after a start.");
`endif

endmodule
